[rtl/u8e_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8e_pkg
// Shared types and constants of the UCS-4 to UTF-8 encoder.
// ---------------------------------------------------------------------------
package u8e_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_W       = 16;
    localparam int TOTAL_W     = 16;
    localparam int CP_W        = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    // comparison width wide enough for the count, the sum and the capacity
    localparam int CMP_W       = 34;

    // queue between front and back, depth a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY = 1'd1;

    localparam logic [CP_W-1:0] LIM_1B = 32'h0000_0080;
    localparam logic [CP_W-1:0] LIM_2B = 32'h0000_0800;
    localparam logic [CP_W-1:0] LIM_3B = 32'h0001_0000;

    localparam logic [7:0] LEAD_2B = 8'hc0;
    localparam logic [7:0] LEAD_3B = 8'he0;
    localparam logic [7:0] LEAD_4B = 8'hf0;
    localparam logic [7:0] CONT_B  = 8'h80;

    localparam logic [CMP_W-1:0] TOTAL_MAX = CMP_W'(16'hffff);

    // one queued item: its bytes and how to present them
    typedef struct packed {
        logic [3:0][7:0]     bytes;
        logic [1:0]          last_idx;
        logic                has_bytes;
        logic                stopped;
        logic [TOTAL_W-1:0]  total;
    } t_job;

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_WIDTH-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w > TOTAL_MAX) begin
            return TOTAL_W'(TOTAL_MAX);
        end
        return TOTAL_W'(w);
    endfunction

endpackage
`default_nettype wire

[rtl/ucs4_to_utf8_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// an accepted item is written into the queue, then the back end registers its
// first result into the output register
// one item per cycle in while the queue is not full, one result per cycle out
// while the output is not stalled; an item gives one result per byte (1 to 4,
// 1 in count-only or stopped cases), set by the byte walker in the back end
// reset: synchronous active-low, clears queue, budget count, halt and config
// ---------------------------------------------------------------------------
// ucs4_to_utf8_encoder_core
// UCS-4 to UTF-8 encoder with per-string byte budget and count-only mode.
// ---------------------------------------------------------------------------
module ucs4_to_utf8_encoder_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [u8e_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [u8e_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [u8e_pkg::CP_W-1:0]        i_code_point,
    input  wire                            i_first_of_string,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_byte_valid,
    output logic                           o_last_of_item,
    output logic [u8e_pkg::TOTAL_W-1:0]    o_total_written,
    output logic                           o_stopped
);
    import u8e_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             r_count_only;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    t_job             job_in;
    t_job             job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= '0;
            r_count_only <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAPACITY:   r_capacity   <= i_cfg_data[CAP_W-1:0];
                CFG_COUNT_ONLY: r_count_only <= i_cfg_data[0];
                default:        r_capacity   <= r_capacity;
            endcase
        end
    end

    u8e_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_code_point      (i_code_point),
        .i_first_of_string (i_first_of_string),
        .i_capacity        (r_capacity),
        .i_count_only      (r_count_only),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_job             (job_in)
    );

    u8e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (job_head)
    );

    u8e_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_head          (job_head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_item  (o_last_of_item),
        .o_total_written (o_total_written),
        .o_stopped       (o_stopped)
    );

endmodule
`default_nettype wire

[rtl/u8e_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8e_front
// Accepts code points, encodes them, keeps the string budget state and
// hands one job per item to the queue.
// ---------------------------------------------------------------------------
module u8e_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire [u8e_pkg::CP_W-1:0]     i_code_point,
    input  wire                         i_first_of_string,
    input  wire [u8e_pkg::CAP_W-1:0]    i_capacity,
    input  wire                         i_count_only,
    input  wire                         i_q_full,
    output logic                        o_push,
    output u8e_pkg::t_job               o_job
);
    import u8e_pkg::*;

    logic [COUNT_WIDTH-1:0] r_bytes_used, n_bytes_used;
    logic                   r_halted, n_halted;

    logic [COUNT_WIDTH-1:0] eff_used;
    logic                   eff_halt;
    logic [2:0]             nbytes;
    logic [3:0][7:0]        enc;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sum_sat;
    logic                   over;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign eff_used = i_first_of_string ? '0 : r_bytes_used;
    assign eff_halt = i_first_of_string ? 1'b0 : r_halted;

    always_comb begin
        enc = '0;
        if (i_code_point < LIM_1B) begin
            nbytes = 3'd1;
            enc[0] = i_code_point[7:0];
        end else if (i_code_point < LIM_2B) begin
            nbytes = 3'd2;
            enc[0] = LEAD_2B | {3'b000, i_code_point[10:6]};
            enc[1] = CONT_B  | {2'b00, i_code_point[5:0]};
        end else if (i_code_point < LIM_3B) begin
            nbytes = 3'd3;
            enc[0] = LEAD_3B | {4'b0000, i_code_point[15:12]};
            enc[1] = CONT_B  | {2'b00, i_code_point[11:6]};
            enc[2] = CONT_B  | {2'b00, i_code_point[5:0]};
        end else begin
            // bits above 20 drop out here
            nbytes = 3'd4;
            enc[0] = LEAD_4B | {5'b00000, i_code_point[20:18]};
            enc[1] = CONT_B  | {2'b00, i_code_point[17:12]};
            enc[2] = CONT_B  | {2'b00, i_code_point[11:6]};
            enc[3] = CONT_B  | {2'b00, i_code_point[5:0]};
        end
    end

    assign sum     = {1'b0, eff_used} + (COUNT_WIDTH+1)'(nbytes);
    assign sum_sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    assign over    = (i_capacity != '0) && (CMP_W'(sum) > CMP_W'(i_capacity));

    always_comb begin
        n_bytes_used    = r_bytes_used;
        n_halted        = r_halted;
        o_job.bytes     = enc;
        o_job.last_idx  = 2'd0;
        o_job.has_bytes = 1'b0;
        o_job.stopped   = 1'b1;
        o_job.total     = sat_total(eff_used);
        if (eff_halt || over) begin
            n_bytes_used = eff_used;
            n_halted     = 1'b1;
        end else begin
            n_bytes_used    = sum_sat;
            n_halted        = 1'b0;
            o_job.stopped   = 1'b0;
            o_job.total     = sat_total(sum_sat);
            o_job.has_bytes = !i_count_only;
            o_job.last_idx  = i_count_only ? 2'd0 : 2'(nbytes - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_used <= '0;
            r_halted     <= 1'b0;
        end else if (o_push) begin
            r_bytes_used <= n_bytes_used;
            r_halted     <= n_halted;
        end
    end

endmodule
`default_nettype wire

[rtl/u8e_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8e_queue
// Small job queue between the front and the back.
// ---------------------------------------------------------------------------
module u8e_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  u8e_pkg::t_job   i_job,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output u8e_pkg::t_job   o_head
);
    import u8e_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/u8e_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8e_back
// Walks the head job one byte per cycle into the output register, while the output is not stalled.
// ---------------------------------------------------------------------------
module u8e_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_empty,
    input  u8e_pkg::t_job               i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_last_of_item,
    output logic [u8e_pkg::TOTAL_W-1:0] o_total_written,
    output logic                        o_stopped
);
    import u8e_pkg::*;

    logic               r_valid;
    logic [1:0]         r_idx;
    logic [7:0]         r_byte;
    logic               r_bvalid;
    logic               r_last;
    logic [TOTAL_W-1:0] r_total;
    logic               r_stop;
    logic               advance;
    logic               take;
    logic               at_last;

    assign advance = !r_valid || i_out_ready;
    assign take    = advance && !i_empty;
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = take && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (advance) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte   <= i_head.has_bytes ? i_head.bytes[r_idx] : 8'h00;
            r_bvalid <= i_head.has_bytes;
            r_last   <= at_last;
            r_total  <= i_head.total;
            r_stop   <= i_head.stopped;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_last_of_item  = r_last;
    assign o_total_written = r_total;
    assign o_stopped       = r_stop;

endmodule
`default_nettype wire

[rtl/u8e_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8e_checker
// Port-level checks of the encoder's result stream.
// ---------------------------------------------------------------------------
module u8e_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          o_out_valid,
    input  wire                          i_out_ready,
    input  wire [7:0]                    o_out_byte,
    input  wire                          o_byte_valid,
    input  wire                          o_last_of_item,
    input  wire [u8e_pkg::TOTAL_W-1:0]   o_total_written,
    input  wire                          o_stopped
);
    import u8e_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_total_written) && $stable(o_last_of_item))
        else $error("u8e: stalled result changed");

    // a stopped result is a single empty result
    a_stop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stopped |-> o_last_of_item && !o_byte_valid
            && (o_out_byte == 8'h00))
        else $error("u8e: stopped result not empty");

    // only emitted bytes can be followed by more results of the same item
    a_mid_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_item |-> o_byte_valid && !o_stopped)
        else $error("u8e: non-final result without byte");

    // count stays fixed across the results of one item
    a_total_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_item |=>
            o_out_valid && $stable(o_total_written))
        else $error("u8e: count changed within an item");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("u8e: result valid after reset");

endmodule

bind ucs4_to_utf8_encoder_core u8e_checker u_u8e_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_last_of_item  (o_last_of_item),
    .o_total_written (o_total_written),
    .o_stopped       (o_stopped)
);
`default_nettype wire
